// ===== hw/rtl/ttbc_pkg.sv =====
// Shared constants and register map for the triangle transform and cull block.
`default_nettype none

package ttbc_pkg;

    localparam int COEF_W      = 16;
    localparam int ROW_W       = 3 * COEF_W;
    localparam int FRAC_SHIFT  = 12;
    localparam int ROUND_BIAS  = 2048;
    localparam int SPLIT_W     = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_IDX_LSB = 3;

    localparam logic [ROW_W-1:0] ROT_X_RST = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] ROT_Y_RST = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] ROT_Z_RST = 48'h1000_0000_0000;

    typedef enum logic [2:0] {
        REG_ROT_ROW_X = 3'd0,
        REG_ROT_ROW_Y = 3'd1,
        REG_ROT_ROW_Z = 3'd2,
        REG_SHIFT_X   = 3'd3,
        REG_SHIFT_Y   = 3'd4,
        REG_SHIFT_Z   = 3'd5
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== hw/rtl/ttbc_xform.sv =====
// Three-stage affine transform of one corner: products, rounded sum, translate and saturate.
`default_nettype none

module ttbc_xform
    import ttbc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  wire                       i_clk,
    input  wire [2:0]                 i_en,
    input  wire [3*COORD_WIDTH-1:0]   i_corner,
    input  wire [ROW_W-1:0]           i_rot_x,
    input  wire [ROW_W-1:0]           i_rot_y,
    input  wire [ROW_W-1:0]           i_rot_z,
    input  wire [COORD_WIDTH-1:0]     i_shift_x,
    input  wire [COORD_WIDTH-1:0]     i_shift_y,
    input  wire [COORD_WIDTH-1:0]     i_shift_z,
    output logic [3*COORD_WIDTH-1:0]  o_corner
);

    localparam int W  = COORD_WIDTH;
    localparam int PW = COEF_W + W;
    localparam int SW = W + 18;
    localparam int QW = SW - FRAC_SHIFT;
    localparam int TW = QW + 1;

    localparam logic signed [TW-1:0] SAT_HI = {{(TW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [TW-1:0] SAT_LO = {{(TW-W+1){1'b1}}, {(W-1){1'b0}}};

    logic        [ROW_W-1:0] rows   [3];
    logic signed [W-1:0]     vin    [3];
    logic signed [W-1:0]     shifts [3];

    logic signed [PW-1:0]    r_prod [3][3];
    logic signed [QW-1:0]    r_q    [3];
    logic signed [W-1:0]     r_c    [3];
    logic signed [SW-1:0]    n_sum  [3];
    logic signed [TW-1:0]    n_t    [3];

    assign rows[0]   = i_rot_x;
    assign rows[1]   = i_rot_y;
    assign rows[2]   = i_rot_z;
    assign shifts[0] = i_shift_x;
    assign shifts[1] = i_shift_y;
    assign shifts[2] = i_shift_z;

    for (genvar k = 0; k < 3; k++) begin : g_vin
        assign vin[k] = i_corner[k*W +: W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[r][k] <= $signed(rows[r][k*COEF_W +: COEF_W]) * vin[k];
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = SW'(r_prod[r][0]) + SW'(r_prod[r][1]) + SW'(r_prod[r][2])
                     + SW'(ROUND_BIAS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int r = 0; r < 3; r++) begin
                r_q[r] <= n_sum[r][SW-1:FRAC_SHIFT];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_t[r] = TW'(r_q[r]) + TW'(shifts[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int r = 0; r < 3; r++) begin
                if (n_t[r] > SAT_HI) begin
                    r_c[r] <= SAT_HI[W-1:0];
                end else if (n_t[r] < SAT_LO) begin
                    r_c[r] <= SAT_LO[W-1:0];
                end else begin
                    r_c[r] <= n_t[r][W-1:0];
                end
            end
        end
    end

    assign o_corner = {r_c[2], r_c[1], r_c[0]};

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_transform_backface_cull_top.sv =====
// Pipeline: 9 register stages lie between the input transfer and m_tvalid of a kept triangle.
// Throughput: one triangle per cycle while the output is not stalled; a stalled output fills pipeline bubbles first.
// Stages: 3 transform, 2 cross product, 2 split 32-bit partial products, 1 sum and sign,
// 1 output register with winding select. Culled triangles produce no transfer.
// Reset (synchronous, active low) clears all valid bits and loads the identity transform.
`default_nettype none

module triangle_transform_backface_cull_top
    import ttbc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // APB configuration
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [CFG_ADDR_W-1:0]   paddr,
    input  wire [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready,
    // slave stream
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // first_x, first_y, first_z, second_x .. second_z, third_x .. third_z, zero pad
    input  wire [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // two_sided
    input  wire [0:0]              s_tuser,
    // master stream
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // out_a_x, out_a_y, out_a_z, out_b_x .. out_b_z, out_c_x .. out_c_z, zero pad
    output logic [((9*COORD_WIDTH+7)/8)*8-1:0] m_tdata
);

    localparam int W      = COORD_WIDTH;
    localparam int VW     = 9 * W;
    localparam int DATA_W = ((VW + 7) / 8) * 8;
    localparam int MW     = 2 * W;
    localparam int CW     = MW + 1;
    localparam int HW     = CW - SPLIT_W;
    localparam int LPW    = W + SPLIT_W + 1;
    localparam int HPW    = W + HW;
    localparam int TW     = 3 * W + 3;

    // configuration
    logic [ROW_W-1:0] r_rot_x, r_rot_y, r_rot_z;
    logic [W-1:0]     r_shift_x, r_shift_y, r_shift_z;
    t_reg_idx         cfg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_x   <= ROT_X_RST;
            r_rot_y   <= ROT_Y_RST;
            r_rot_z   <= ROT_Z_RST;
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_shift_z <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ROT_ROW_X: r_rot_x   <= pwdata[ROW_W-1:0];
                REG_ROT_ROW_Y: r_rot_y   <= pwdata[ROW_W-1:0];
                REG_ROT_ROW_Z: r_rot_z   <= pwdata[ROW_W-1:0];
                REG_SHIFT_X:   r_shift_x <= pwdata[W-1:0];
                REG_SHIFT_Y:   r_shift_y <= pwdata[W-1:0];
                REG_SHIFT_Z:   r_shift_z <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ROT_ROW_X: prdata = CFG_DATA_W'(r_rot_x);
            REG_ROT_ROW_Y: prdata = CFG_DATA_W'(r_rot_y);
            REG_ROT_ROW_Z: prdata = CFG_DATA_W'(r_rot_z);
            REG_SHIFT_X:   prdata = CFG_DATA_W'(r_shift_x);
            REG_SHIFT_Y:   prdata = CFG_DATA_W'(r_shift_y);
            REG_SHIFT_Z:   prdata = CFG_DATA_W'(r_shift_z);
            default:       prdata = '0;
        endcase
    end

    // pipeline control: stage k loads when empty or when stage k+1 loads
    logic [8:1] r_v;
    logic [9:1] en;
    logic       r_out_v;

    always_comb begin
        en[9] = !r_out_v || m_tready;
        for (int k = 8; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign s_tready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= s_tvalid;
            end
            for (int k = 2; k <= 8; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // two_sided flag follows the item
    logic [8:1] r_ts;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_ts[1] <= s_tuser[0];
        end
        for (int k = 2; k <= 8; k++) begin
            if (en[k]) begin
                r_ts[k] <= r_ts[k-1];
            end
        end
    end

    // stages 1..3: corner transforms
    logic [VW-1:0] vtx3;

    for (genvar c = 0; c < 3; c++) begin : g_xf
        ttbc_xform #(
            .COORD_WIDTH (W)
        ) u_xform (
            .i_clk     (i_clk),
            .i_en      (en[3:1]),
            .i_corner  (s_tdata[c*3*W +: 3*W]),
            .i_rot_x   (r_rot_x),
            .i_rot_y   (r_rot_y),
            .i_rot_z   (r_rot_z),
            .i_shift_x (r_shift_x),
            .i_shift_y (r_shift_y),
            .i_shift_z (r_shift_z),
            .o_corner  (vtx3[c*3*W +: 3*W])
        );
    end

    // stage 4: B' x C' partial products
    logic signed [MW-1:0] r_m [6];
    logic [VW-1:0]        r_vtx4, r_vtx5, r_vtx6, r_vtx7, r_vtx8;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                r_m[2*i]   <= $signed(vtx3[(3+(i+1)%3)*W +: W])
                            * $signed(vtx3[(6+(i+2)%3)*W +: W]);
                r_m[2*i+1] <= $signed(vtx3[(3+(i+2)%3)*W +: W])
                            * $signed(vtx3[(6+(i+1)%3)*W +: W]);
            end
            r_vtx4 <= vtx3;
        end
    end

    // stage 5: cross product components
    logic signed [CW-1:0] r_cr [3];

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int i = 0; i < 3; i++) begin
                r_cr[i] <= CW'(r_m[2*i]) - CW'(r_m[2*i+1]);
            end
            r_vtx5 <= r_vtx4;
        end
    end

    // stage 6: A' times cross, split into low and high partial products
    logic signed [LPW-1:0] r_pl [3];
    logic signed [HPW-1:0] r_ph [3];

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            for (int i = 0; i < 3; i++) begin
                r_pl[i] <= $signed(r_vtx5[i*W +: W])
                         * $signed({1'b0, r_cr[i][SPLIT_W-1:0]});
                r_ph[i] <= $signed(r_vtx5[i*W +: W])
                         * $signed(r_cr[i][CW-1:SPLIT_W]);
            end
            r_vtx6 <= r_vtx5;
        end
    end

    // stage 7: recombine partial products
    logic signed [TW-1:0] r_term [3];

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            for (int i = 0; i < 3; i++) begin
                r_term[i] <= (TW'(r_ph[i]) <<< SPLIT_W) + TW'(r_pl[i]);
            end
            r_vtx7 <= r_vtx6;
        end
    end

    // stage 8: triple product sign
    logic signed [TW-1:0] n_triple;
    logic                 r_front;

    assign n_triple = r_term[0] + r_term[1] + r_term[2];

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_front <= !n_triple[TW-1] && (|n_triple);
            r_vtx8  <= r_vtx7;
        end
    end

    // output register: front-facing reverses the winding, culled items drop
    logic [VW-1:0] r_out_vtx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en[9]) begin
            r_out_v <= r_v[8] && (r_front || r_ts[8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            if (r_front) begin
                r_out_vtx <= {r_vtx8[3*W-1:0], r_vtx8[6*W-1:3*W], r_vtx8[VW-1:6*W]};
            end else begin
                r_out_vtx <= r_vtx8;
            end
        end
    end

    assign m_tvalid = r_out_v;
    assign m_tdata  = DATA_W'(r_out_vtx);

endmodule

`default_nettype wire
